/* design/assert_macros.svh */
// Assertion macros for the gearbox / PTO sequencer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define GPSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled while reset is asserted
`define GPSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GPSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define GPSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* design/gpss_pkg.sv */
// Shared types and constants for the gearbox / PTO shift sequencer.
// No dependencies; imported by every module of the block.
package gpss_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ENGAGE_WAIT  = 2'd0;
  localparam logic [1:0] CFG_RELEASE_WAIT = 2'd1;
  localparam logic [1:0] CFG_ALIGN_COUNT  = 2'd2;
  localparam logic [1:0] CFG_ALIGN_POWER  = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] ENGAGE_WAIT_RST  = 16'd250;
  localparam logic [15:0] RELEASE_WAIT_RST = 16'd1000;
  localparam logic [14:0] ALIGN_COUNT_RST  = 15'd90;
  localparam logic [14:0] ALIGN_POWER_RST  = 15'd9830;

  // sequence step codes (engage uses all, release uses start/wait1 and ends on align_l)
  typedef enum logic [2:0] {
    STEP_START   = 3'd0,
    STEP_WAIT1   = 3'd1,
    STEP_WAIT2   = 3'd2,
    STEP_ALIGN_L = 3'd3,
    STEP_ALIGN_R = 3'd4,
    STEP_DONE    = 3'd5
  } step_t;

  typedef struct packed {
    logic [15:0] engage_wait_ms;
    logic [15:0] release_wait_ms;
    logic [14:0] align_count;
    logic [14:0] align_power;
  } cfg_t;

  // one input beat
  typedef struct packed {
    logic               shift_button;
    logic               pto_button;
    logic               sync_button;
    logic signed [15:0] stick_left;
    logic signed [15:0] stick_right;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
    logic [7:0]         elapsed_ms;
  } item_t;

  // one result beat
  typedef struct packed {
    logic               high_gear_out;
    logic               pto_engage_out;
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               encoder_clear;
    logic               pto_mode;
    logic               driver_locked;
  } res_t;

  // sequencer state
  typedef struct packed {
    logic               last_shift;
    logic               last_pto;
    logic               gear_high;
    logic               pto_engaged;
    logic               in_pto_mode;
    logic               going_to_pto;
    logic               going_to_drive;
    step_t              seq_step;
    logic [15:0]        wait_timer;
    logic               input_lock;
    logic signed [15:0] left_cmd;
    logic signed [15:0] right_cmd;
  } state_t;

endpackage

/* design/gpss_cfg_regs.sv */
// Configuration register file for the gearbox / PTO sequencer.
// Depends on gpss_pkg for index codes, reset values and cfg_t.
module gpss_cfg_regs import gpss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ENGAGE_WAIT:  cfg_nxt.engage_wait_ms  = cfg_wdata;
        CFG_RELEASE_WAIT: cfg_nxt.release_wait_ms = cfg_wdata;
        CFG_ALIGN_COUNT:  cfg_nxt.align_count     = cfg_wdata[14:0];
        CFG_ALIGN_POWER:  cfg_nxt.align_power     = cfg_wdata[14:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.engage_wait_ms  <= ENGAGE_WAIT_RST;
      cfg_r.release_wait_ms <= RELEASE_WAIT_RST;
      cfg_r.align_count     <= ALIGN_COUNT_RST;
      cfg_r.align_power     <= ALIGN_POWER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/gpss_seq_core.sv */
// Sequencer state and one-tick step logic: button edges, engage/release
// sequence, wait timer and tank mix. Depends on gpss_pkg.
module gpss_seq_core import gpss_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   step_en,
  input  cfg_t   cfg,
  input  item_t  item,
  output res_t   res,
  output state_t st
);

  state_t st_r, st_nxt;

  logic               sync_on;
  logic               clear;
  logic               hg_out;
  logic [16:0]        tsum;
  logic signed [15:0] l_mix;
  logic signed [15:0] r_neg;
  logic signed [15:0] align_cnt_s;
  logic signed [15:0] align_pwr_s;

  assign align_cnt_s = $signed({1'b0, cfg.align_count});
  assign align_pwr_s = $signed({1'b0, cfg.align_power});
  assign tsum        = {1'b0, st_r.wait_timer} + {9'd0, item.elapsed_ms};
  assign r_neg       = (item.stick_right == 16'sh8000) ? 16'sh7fff : -item.stick_right;

  // next state for one tick
  always_comb begin
    st_nxt  = st_r;
    clear   = 1'b0;
    sync_on = item.sync_button & st_r.in_pto_mode;
    l_mix   = item.stick_left;

    // gear toggle on shift edge
    if (item.shift_button && !st_r.last_shift) begin
      st_nxt.gear_high = ~st_r.gear_high;
    end
    st_nxt.last_shift = item.shift_button;

    // PTO edge picks the sequence and restarts it
    if (item.pto_button && !st_r.last_pto) begin
      st_nxt.going_to_drive = st_r.in_pto_mode;
      st_nxt.going_to_pto   = ~st_r.in_pto_mode;
      st_nxt.seq_step       = STEP_START;
      st_nxt.input_lock     = 1'b0;
    end
    st_nxt.last_pto = item.pto_button;

    hg_out = st_nxt.gear_high;

    // saturating wait timer
    st_nxt.wait_timer = tsum[16] ? 16'hffff : tsum[15:0];

    // sequence step
    if (st_nxt.going_to_pto) begin
      case (st_nxt.seq_step)
        STEP_START: begin
          st_nxt.gear_high   = 1'b0;
          st_nxt.pto_engaged = 1'b0;
          st_nxt.wait_timer  = '0;
          st_nxt.seq_step    = STEP_WAIT1;
        end
        STEP_WAIT1: begin
          if (st_nxt.wait_timer >= cfg.engage_wait_ms) begin
            st_nxt.pto_engaged = 1'b1;
            st_nxt.seq_step    = STEP_WAIT2;
            st_nxt.wait_timer  = '0;
            st_nxt.in_pto_mode = 1'b1;
          end
        end
        STEP_WAIT2: begin
          if (st_nxt.wait_timer >= cfg.engage_wait_ms) begin
            clear             = 1'b1;
            st_nxt.left_cmd   = align_pwr_s;
            st_nxt.seq_step   = STEP_ALIGN_L;
            st_nxt.input_lock = 1'b1;
          end
        end
        STEP_ALIGN_L: begin
          if (item.left_count >= align_cnt_s) begin
            st_nxt.left_cmd  = '0;
            clear            = 1'b1;
            st_nxt.right_cmd = -align_pwr_s;
            st_nxt.seq_step  = STEP_ALIGN_R;
          end
        end
        STEP_ALIGN_R: begin
          if (item.right_count >= align_cnt_s) begin
            st_nxt.right_cmd    = '0;
            st_nxt.seq_step     = STEP_DONE;
            st_nxt.going_to_pto = 1'b0;
            st_nxt.input_lock   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else if (st_nxt.going_to_drive) begin
      case (st_nxt.seq_step)
        STEP_START: begin
          st_nxt.pto_engaged = 1'b0;
          st_nxt.wait_timer  = '0;
          st_nxt.seq_step    = STEP_WAIT1;
        end
        STEP_WAIT1: begin
          if (st_nxt.wait_timer >= cfg.release_wait_ms) begin
            st_nxt.gear_high      = 1'b1;
            st_nxt.seq_step       = STEP_ALIGN_L;
            st_nxt.going_to_drive = 1'b0;
            st_nxt.in_pto_mode    = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    // tank mix: right inverted, left clamped at zero in PTO, optional mirror
    if (!st_nxt.input_lock) begin
      if (st_nxt.in_pto_mode && l_mix <= 0) l_mix = '0;
      if (sync_on) begin
        if (l_mix <= 0) l_mix = '0;
        st_nxt.left_cmd  = l_mix;
        st_nxt.right_cmd = -l_mix;
      end else begin
        st_nxt.left_cmd  = l_mix;
        st_nxt.right_cmd = r_neg;
      end
    end
  end

  // result of this tick
  always_comb begin
    res.high_gear_out  = hg_out;
    res.pto_engage_out = st_r.pto_engaged;
    res.left_drive     = st_nxt.left_cmd;
    res.right_drive    = st_nxt.right_cmd;
    res.encoder_clear  = clear;
    res.pto_mode       = st_nxt.in_pto_mode;
    res.driver_locked  = st_nxt.input_lock;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.last_shift     <= 1'b0;
      st_r.last_pto       <= 1'b0;
      st_r.gear_high      <= 1'b1;
      st_r.pto_engaged    <= 1'b0;
      st_r.in_pto_mode    <= 1'b0;
      st_r.going_to_pto   <= 1'b0;
      st_r.going_to_drive <= 1'b0;
      st_r.seq_step       <= STEP_START;
      st_r.wait_timer     <= '0;
      st_r.input_lock     <= 1'b0;
      st_r.left_cmd       <= '0;
      st_r.right_cmd      <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

  assign st = st_r;

endmodule

/* design/gearbox_pto_shift_sequencer.sv */
// Gearbox / PTO shift sequencer top level: input register, step core,
// result register. Depends on gpss_pkg, gpss_cfg_regs, gpss_seq_core.
//
// Use: one input beat per control tick carries button levels, stick
// commands, encoder counts and the ms elapsed since the previous tick.
// Each input beat yields exactly one result beat with the solenoid
// outputs, held motor commands, encoder clear pulse and mode flags.
// Both channels use valid/stall; a beat moves when valid is high and
// stall is low. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_wdata); the user must write it only while no beat is in flight;
// the block itself does not enforce this. An accepted beat loads the
// input register; the step logic then fills the result register,
// which raises out_valid.
// Throughput: one beat per cycle while the receiver does not stall;
// the state update is a single pass through the step logic.
// Reset (rst_n low, synchronous) empties both registers, returns the
// sequencer to high gear, PTO disengaged, and loads register defaults.
// When the receiver stalls, the result is held; one more beat can sit
// in the input register, after which in_stall is raised.
module gearbox_pto_shift_sequencer import gpss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_shift_button,
  input  logic                  in_pto_button,
  input  logic                  in_sync_button,
  input  logic signed [15:0]    in_stick_left,
  input  logic signed [15:0]    in_stick_right,
  input  logic signed [15:0]    in_left_count,
  input  logic signed [15:0]    in_right_count,
  input  logic [7:0]            in_elapsed_ms,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_high_gear_out,
  output logic                  out_pto_engage_out,
  output logic signed [15:0]    out_left_drive,
  output logic signed [15:0]    out_right_drive,
  output logic                  out_encoder_clear,
  output logic                  out_pto_mode,
  output logic                  out_driver_locked
);

`include "assert_macros.svh"

  cfg_t   cfg;
  item_t  item_r, item_nxt;
  res_t   res, res_r;
  state_t st;
  logic   item_vld_r, item_vld_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   out_ready;
  logic   in_acc;
  logic   step_fire;

  gpss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake: result register frees up when empty or being taken
  assign out_ready = ~out_vld_r | ~out_stall;
  assign step_fire = item_vld_r & out_ready;
  assign in_stall  = item_vld_r & ~out_ready;
  assign in_acc    = in_valid & ~in_stall;

  always_comb begin
    item_nxt.shift_button = in_shift_button;
    item_nxt.pto_button   = in_pto_button;
    item_nxt.sync_button  = in_sync_button;
    item_nxt.stick_left   = in_stick_left;
    item_nxt.stick_right  = in_stick_right;
    item_nxt.left_count   = in_left_count;
    item_nxt.right_count  = in_right_count;
    item_nxt.elapsed_ms   = in_elapsed_ms;
  end

  always_comb begin
    item_vld_nxt = in_acc | (item_vld_r & ~step_fire);
    out_vld_nxt  = step_fire | (out_vld_r & out_stall);
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= item_nxt;
    end
  end

  gpss_seq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_fire),
    .cfg     (cfg),
    .item    (item_r),
    .res     (res),
    .st      (st)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_high_gear_out  = res_r.high_gear_out;
  assign out_pto_engage_out = res_r.pto_engage_out;
  assign out_left_drive     = res_r.left_drive;
  assign out_right_drive    = res_r.right_drive;
  assign out_encoder_clear  = res_r.encoder_clear;
  assign out_pto_mode       = res_r.pto_mode;
  assign out_driver_locked  = res_r.driver_locked;

  // checks
  `GPSS_ASSERT_IMPL(a_stall_needs_item, clk, rst_n, in_stall, item_vld_r, "stall with empty input register")
  `GPSS_ASSERT_IMPL(a_one_sequence, clk, rst_n, st.going_to_pto, !st.going_to_drive, "both sequences active")
  `GPSS_ASSERT_IMPL(a_lock_in_pto, clk, rst_n, st.input_lock, st.in_pto_mode, "driver locked outside PTO mode")
  `GPSS_ASSERT_IMPL(a_clear_locked, clk, rst_n, out_vld_r && out_encoder_clear, out_driver_locked, "encoder clear without lock")
  `GPSS_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, step_fire, out_vld_r, "step without result")

endmodule

/* verif/tb.sv */
// Self-checking testbench for gearbox_pto_shift_sequencer: directed ticks, then random
// phases under several config settings and idle/stall mixes. Needs gpss_pkg and the RTL.
module tb;
  import gpss_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 80;
  localparam int MAX_REPORTS = 10;

  // Tracks sequencer state per accepted input beat and checks result beats in order.
  class pto_sequencer_board;
    cfg_t               regs;
    logic               last_shift, last_pto, gear_high, pto_engaged, in_pto;
    logic               to_pto, to_drive, lock;
    step_t              seq_pos;
    int unsigned        wait_ms;
    logic signed [15:0] left_cmd, right_cmd;
    res_t               pending[$];
    int                 failures;

    function new();
      regs.engage_wait_ms  = ENGAGE_WAIT_RST;
      regs.release_wait_ms = RELEASE_WAIT_RST;
      regs.align_count     = ALIGN_COUNT_RST;
      regs.align_power     = ALIGN_POWER_RST;
      last_shift = 0; last_pto = 0; gear_high = 1; pto_engaged = 0; in_pto = 0;
      to_pto = 0; to_drive = 0; lock = 0;
      seq_pos = STEP_START; wait_ms = 0; left_cmd = 0; right_cmd = 0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_ENGAGE_WAIT:  regs.engage_wait_ms  = val;
        CFG_RELEASE_WAIT: regs.release_wait_ms = val;
        CFG_ALIGN_COUNT:  regs.align_count     = val[14:0];
        CFG_ALIGN_POWER:  regs.align_power     = val[14:0];
        default: ;
      endcase
    endfunction

    // one control tick: edges, solenoid snapshot, timer, sequence step, tank mix
    function void note_tick(item_t it);
      res_t e;
      int   l, r;
      logic sync_on, clr, hg, pe;
      sync_on = it.sync_button && in_pto;
      clr = 0;
      if (it.shift_button && !last_shift) gear_high = !gear_high;
      last_shift = it.shift_button;
      // PTO edge restarts the requested sequence
      if (it.pto_button && !last_pto) begin
        if (in_pto) begin
          to_drive = 1; to_pto = 0;
        end else begin
          to_pto = 1; to_drive = 0;
        end
        seq_pos = STEP_START;
        lock = 0;
      end
      last_pto = it.pto_button;
      hg = gear_high;
      pe = pto_engaged;
      wait_ms += it.elapsed_ms;
      if (wait_ms > 65535) wait_ms = 65535;
      // engage sequence
      if (to_pto) begin
        case (seq_pos)
          STEP_START: begin
            gear_high = 0; pto_engaged = 0; wait_ms = 0; seq_pos = STEP_WAIT1;
          end
          STEP_WAIT1: begin
            if (wait_ms >= regs.engage_wait_ms) begin
              pto_engaged = 1; seq_pos = STEP_WAIT2; wait_ms = 0; in_pto = 1;
            end
          end
          STEP_WAIT2: begin
            if (wait_ms >= regs.engage_wait_ms) begin
              clr = 1; left_cmd = {1'b0, regs.align_power};
              seq_pos = STEP_ALIGN_L; lock = 1;
            end
          end
          STEP_ALIGN_L: begin
            if (int'(it.left_count) >= int'(regs.align_count)) begin
              left_cmd = 0; clr = 1;
              right_cmd = -$signed({1'b0, regs.align_power});
              seq_pos = STEP_ALIGN_R;
            end
          end
          STEP_ALIGN_R: begin
            if (int'(it.right_count) >= int'(regs.align_count)) begin
              right_cmd = 0; seq_pos = STEP_DONE; to_pto = 0; lock = 0;
            end
          end
          default: ;
        endcase
      // release sequence
      end else if (to_drive) begin
        case (seq_pos)
          STEP_START: begin
            pto_engaged = 0; wait_ms = 0; seq_pos = STEP_WAIT1;
          end
          STEP_WAIT1: begin
            if (wait_ms >= regs.release_wait_ms) begin
              gear_high = 1; seq_pos = STEP_ALIGN_L; to_drive = 0; in_pto = 0;
            end
          end
          default: ;
        endcase
      end
      // tank mix: right inverted (saturating), left clamped at zero in PTO
      if (!lock) begin
        l = int'(it.stick_left);
        r = (it.stick_right == -32768) ? 32767 : -int'(it.stick_right);
        if (in_pto && l <= 0) l = 0;
        if (sync_on) begin
          if (l <= 0) l = 0;
          left_cmd = 16'(l); right_cmd = 16'(-l);
        end else begin
          left_cmd = 16'(l); right_cmd = 16'(r);
        end
      end
      e.high_gear_out  = hg;
      e.pto_engage_out = pe;
      e.left_drive     = left_cmd;
      e.right_drive    = right_cmd;
      e.encoder_clear  = clr;
      e.pto_mode       = in_pto;
      e.driver_locked  = lock;
      pending.push_back(e);
    endfunction

    function void compare_field(string name, logic signed [16:0] expv,
                                logic signed [16:0] gotv);
      if (expv !== gotv) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%s: expected %0d, got %0d", name, expv, gotv);
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) $display("result beat with nothing outstanding");
        return;
      end
      e = pending.pop_front();
      compare_field("high_gear_out", e.high_gear_out, got.high_gear_out);
      compare_field("pto_engage_out", e.pto_engage_out, got.pto_engage_out);
      compare_field("left_drive", e.left_drive, got.left_drive);
      compare_field("right_drive", e.right_drive, got.right_drive);
      compare_field("encoder_clear", e.encoder_clear, got.encoder_clear);
      compare_field("pto_mode", e.pto_mode, got.pto_mode);
      compare_field("driver_locked", e.driver_locked, got.driver_locked);
    endfunction

    // anything still outstanding at the end is a failure
    function void close_out();
      if (pending.size() != 0) begin
        failures += pending.size();
        $display("%0d result beats never arrived", pending.size());
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ENGAGE_WAIT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_shift_button = 1'b0;
  logic                  in_pto_button = 1'b0;
  logic                  in_sync_button = 1'b0;
  logic signed [15:0]    in_stick_left = '0;
  logic signed [15:0]    in_stick_right = '0;
  logic signed [15:0]    in_left_count = '0;
  logic signed [15:0]    in_right_count = '0;
  logic [7:0]            in_elapsed_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_high_gear_out;
  logic                  out_pto_engage_out;
  logic signed [15:0]    out_left_drive;
  logic signed [15:0]    out_right_drive;
  logic                  out_encoder_clear;
  logic                  out_pto_mode;
  logic                  out_driver_locked;

  pto_sequencer_board board = new();

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int pto_flip_pm = 60;
  int el_floor = 0;
  bit shift_lvl = 0, pto_lvl = 0, sync_lvl = 0;
  item_t seen_tick;
  res_t  seen_res;

  gearbox_pto_shift_sequencer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_shift_button    (in_shift_button),
    .in_pto_button      (in_pto_button),
    .in_sync_button     (in_sync_button),
    .in_stick_left      (in_stick_left),
    .in_stick_right     (in_stick_right),
    .in_left_count      (in_left_count),
    .in_right_count     (in_right_count),
    .in_elapsed_ms      (in_elapsed_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_high_gear_out  (out_high_gear_out),
    .out_pto_engage_out (out_pto_engage_out),
    .out_left_drive     (out_left_drive),
    .out_right_drive    (out_right_drive),
    .out_encoder_clear  (out_encoder_clear),
    .out_pto_mode       (out_pto_mode),
    .out_driver_locked  (out_driver_locked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("gearbox_pto_shift_sequencer: mismatch");
      $finish;
    end
  end

  // monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        seen_tick.shift_button = in_shift_button;
        seen_tick.pto_button   = in_pto_button;
        seen_tick.sync_button  = in_sync_button;
        seen_tick.stick_left   = in_stick_left;
        seen_tick.stick_right  = in_stick_right;
        seen_tick.left_count   = in_left_count;
        seen_tick.right_count  = in_right_count;
        seen_tick.elapsed_ms   = in_elapsed_ms;
        board.note_tick(seen_tick);
      end
      if (out_valid && !out_stall) begin
        seen_res.high_gear_out  = out_high_gear_out;
        seen_res.pto_engage_out = out_pto_engage_out;
        seen_res.left_drive     = out_left_drive;
        seen_res.right_drive    = out_right_drive;
        seen_res.encoder_clear  = out_encoder_clear;
        seen_res.pto_mode       = out_pto_mode;
        seen_res.driver_locked  = out_driver_locked;
        board.check_result(seen_res);
      end
    end
  end

  // receiver: long hold-off when requested, else random stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic item_t tick_of(bit sh, bit pt, bit sy, int sl, int sr, int lc, int rc,
                                    int el);
    item_t t;
    t.shift_button = sh;
    t.pto_button   = pt;
    t.sync_button  = sy;
    t.stick_left   = 16'(sl);
    t.stick_right  = 16'(sr);
    t.left_count   = 16'(lc);
    t.right_count  = 16'(rc);
    t.elapsed_ms   = 8'(el);
    return t;
  endfunction

  // encoder count: mostly near the alignment target, sometimes anywhere
  function automatic logic [15:0] pick_count();
    int v;
    if ($urandom_range(0, 99) < 20) return 16'($urandom);
    v = int'(board.regs.align_count) + int'($urandom_range(0, 9)) - 7;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  function automatic logic [15:0] pick_stick();
    case ($urandom_range(0, 19))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // button levels persist and flip now and then, so edges come in runs
  function automatic item_t make_tick();
    item_t t;
    if ($urandom_range(0, 999) < 60) shift_lvl = !shift_lvl;
    if ($urandom_range(0, 999) < pto_flip_pm) pto_lvl = !pto_lvl;
    if ($urandom_range(0, 999) < 150) sync_lvl = !sync_lvl;
    t.shift_button = shift_lvl;
    t.pto_button   = pto_lvl;
    t.sync_button  = sync_lvl;
    t.stick_left   = pick_stick();
    t.stick_right  = pick_stick();
    t.left_count   = pick_count();
    t.right_count  = pick_count();
    t.elapsed_ms   = 8'($urandom_range(el_floor, 255));
    return t;
  endfunction

  // offer one beat from a falling edge and hold it until accepted
  task automatic send_tick(item_t t);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_shift_button = t.shift_button;
    in_pto_button   = t.pto_button;
    in_sync_button  = t.sync_button;
    in_stick_left   = t.stick_left;
    in_stick_right  = t.stick_right;
    in_left_count   = t.left_count;
    in_right_count  = t.right_count;
    in_elapsed_ms   = t.elapsed_ms;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle();
    in_valid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    board.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic write_cfg(int ew, int rw, int ac, int ap);
    write_reg(CFG_ENGAGE_WAIT, 16'(ew));
    write_reg(CFG_RELEASE_WAIT, 16'(rw));
    write_reg(CFG_ALIGN_COUNT, 16'(ac));
    write_reg(CFG_ALIGN_POWER, 16'(ap));
    cfg_we = 1'b0;
  endtask

  task automatic run_random(int count, int hold_at, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_left = LONG_HOLD;
      if (i == pause_at) begin
        in_valid = 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
      end
      send_tick(make_tick());
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed ticks on reset config
    send_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick_of(0, 0, 0, 32767, -32768, 32767, 32767, 255));
    send_tick(tick_of(0, 0, 1, -32768, 32767, -32768, -32768, 0));
    send_tick(tick_of(1, 0, 0, 100, -100, 0, 0, 10));   // shift edge
    send_tick(tick_of(1, 0, 0, 100, -100, 0, 0, 10));   // held, no toggle
    send_tick(tick_of(0, 0, 0, 100, -100, 0, 0, 10));
    send_tick(tick_of(0, 1, 0, 200, 200, 0, 0, 0));     // engage starts
    send_tick(tick_of(0, 1, 0, 200, 200, 0, 0, 255));   // engaged, PTO mode
    send_tick(tick_of(0, 1, 1, -5, 0, 0, 0, 100));      // left clamp in PTO
    send_tick(tick_of(0, 0, 1, 0, 0, 0, 0, 200));       // alignment starts, locked
    send_tick(tick_of(0, 0, 0, 0, 0, 89, 0, 0));
    send_tick(tick_of(0, 0, 0, 0, 0, 90, 0, 0));        // left aligned
    send_tick(tick_of(0, 0, 1, 1000, 0, 0, 89, 0));
    send_tick(tick_of(0, 0, 1, 1000, 0, 0, 32767, 0));  // right aligned, mirrored mix
    send_tick(tick_of(0, 0, 1, -32768, 5, 0, 0, 0));
    send_tick(tick_of(0, 1, 0, 0, 0, 0, 0, 0));         // release starts
    repeat (4) send_tick(tick_of(0, 1, 0, 0, 0, 0, 0, 255));
    send_tick(tick_of(1, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick_of(0, 1, 0, 0, 0, 0, 0, 0));         // engage again
    send_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 255));
    send_tick(tick_of(0, 1, 0, 0, 0, 0, 0, 0));         // PTO edge mid-sequence
    send_tick(tick_of(1, 1, 1, -1, -1, -1, -1, 255));
    shift_lvl = 1; pto_lvl = 1; sync_lvl = 1;
    settle();

    // all registers at zero, no idling
    write_cfg(0, 0, 0, 0);
    idle_pct = 0; stall_pct = 0;
    run_random(250, -1, -1);
    settle();

    // short waits, sender idles
    write_cfg(100, 300, 40, 9830);
    idle_pct = 71; stall_pct = 0;
    run_random(250, -1, -1);
    settle();

    // all registers at max: timer has to saturate, receiver stalls
    write_cfg(65535, 65535, 32767, 32767);
    idle_pct = 0; stall_pct = 71;
    pto_flip_pm = 2; el_floor = 180;
    send_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 255));
    send_tick(tick_of(0, 1, 0, 0, 0, 0, 0, 255));
    pto_lvl = 1;
    run_random(350, -1, -1);
    settle();

    // reset-like values, both sides idle
    write_cfg(250, 1000, 90, 9830);
    idle_pct = 38; stall_pct = 38;
    pto_flip_pm = 60; el_floor = 0;
    run_random(250, -1, -1);
    settle();

    // random config with a long receiver hold-off and a sender pause
    write_cfg($urandom_range(0, 600), $urandom_range(0, 1500), $urandom_range(0, 200),
              $urandom_range(0, 32767));
    idle_pct = 10; stall_pct = 10;
    run_random(250, 60, 150);
    settle();

    repeat (10) @(negedge clk);
    board.close_out();
    if (board.failures == 0) begin
      $display("gearbox_pto_shift_sequencer: match");
    end else begin
      $display("gearbox_pto_shift_sequencer: mismatch");
    end
    $finish;
  end
endmodule
